/* rtl/scs1_pkg.sv */
package scs1_pkg;

  localparam logic [7:0] PREFIX_CODE       = 8'hE0;
  localparam logic [6:0] KEY_CTRL          = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT        = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT        = 7'h36;
  localparam logic [6:0] KEY_ALT           = 7'h38;
  localparam logic [6:0] KEY_CAPS          = 7'h3A;
  localparam logic [6:0] KEY_FIRST_UNSUPP  = 7'h3B;
  localparam logic [6:0] KEY_LAST_SHIFT_ON = 7'h0E;
  localparam int         ROM_DEPTH         = 59;

  // Unshifted column of the key ROM.
  localparam logic [6:0] ROM_LO [ROM_DEPTH] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  // Shifted column of the key ROM.
  localparam logic [6:0] ROM_HI [ROM_DEPTH] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  typedef struct packed {
    logic prefix;
    logic ctrl;
    logic shift;
    logic alt;
    logic caps;
  } kbd_state_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] ascii_char;
    logic       unknown_key;
  } key_result_t;

  function automatic logic [6:0] rom_lookup(input logic [5:0] idx, input logic sh);
    logic [6:0] c;
    c = 7'h00;
    if (idx < 6'(ROM_DEPTH)) begin
      c = sh ? ROM_HI[idx] : ROM_LO[idx];
    end
    return c;
  endfunction

endpackage

/* rtl/scs1_decode.sv */
module scs1_decode
  import scs1_pkg::*;
(
  input  logic [7:0]  scan_byte,
  input  kbd_state_t  state_cur,
  output kbd_state_t  state_nxt,
  output key_result_t result
);

  logic [6:0] low7;
  logic       ext;
  logic       supported;
  logic       shift_only;
  logic       sh;
  logic [6:0] c;

  assign low7 = scan_byte[6:0];
  assign ext  = state_cur.prefix;

  always_comb begin
    shift_only = (low7 < KEY_LAST_SHIFT_ON) ||
                 (low7 inside {7'h29, 7'h1A, 7'h1B, 7'h2B, 7'h27, 7'h28,
                               7'h33, 7'h34, 7'h35});
    shift_only = shift_only && !ext;
    sh = shift_only ? state_cur.shift : (state_cur.shift ^ state_cur.caps);
    c  = rom_lookup(low7[5:0], sh);
    supported = ext ? (low7 == KEY_CTRL || low7 == KEY_ALT)
                    : (low7 != 7'h00 && low7 < KEY_FIRST_UNSUPP);
  end

  always_comb begin
    state_nxt = state_cur;
    result    = '0;
    if (scan_byte == PREFIX_CODE) begin
      state_nxt.prefix = 1'b1;
    end else begin
      state_nxt.prefix = 1'b0;
      if (scan_byte[7]) begin
        // Break code: release modifiers only.
        if (low7 == KEY_CTRL) begin
          state_nxt.ctrl = 1'b0;
        end else if (!ext && (low7 == KEY_LSHIFT || low7 == KEY_RSHIFT)) begin
          state_nxt.shift = 1'b0;
        end else if (low7 == KEY_ALT) begin
          state_nxt.alt = 1'b0;
        end
      end else if (supported) begin
        if (c != 7'h00) begin
          result.char_valid = 1'b1;
          result.ascii_char = c;
        end else if (low7 == KEY_CTRL) begin
          state_nxt.ctrl = 1'b1;
        end else if (low7 == KEY_LSHIFT || low7 == KEY_RSHIFT) begin
          state_nxt.shift = 1'b1;
        end else if (low7 == KEY_ALT) begin
          state_nxt.alt = 1'b1;
        end else if (low7 == KEY_CAPS) begin
          state_nxt.caps = !state_cur.caps;
        end
      end else begin
        result.unknown_key = 1'b1;
      end
    end
  end

endmodule

/* rtl/scancode_set1_to_ascii.sv */
// Scan code set 1 to ASCII decoder.
// Input channel: in_valid / in_ready carry one raw keyboard byte per
// transaction on in_scan_byte (0xE0 is the extended prefix).
// Output channel: out_valid / out_ready carry exactly one result per input
// transaction: the character (out_char_valid, out_ascii_char), an
// unknown-key flag and the ctrl, shift, alt and caps-lock state after the
// byte.
// out_valid rises when the decoded byte reaches the result register: an
// input register, then the decode into the result register.
// Throughput: one transaction per cycle while out_ready is high, set by the
// single decode stage that reads and updates the modifier flags.
// Reset (rst_n low, synchronous): both stages empty, prefix and all
// modifier flags cleared.
// Stall: when out_ready is low the result holds; the input register still
// takes one more byte, then in_ready drops until the result is taken.
module scancode_set1_to_ascii
  import scs1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_char_valid,
  output logic [6:0] out_ascii_char,
  output logic       out_unknown_key,
  output logic       out_ctrl_down,
  output logic       out_shift_down,
  output logic       out_alt_down,
  output logic       out_caps_on
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  kbd_state_t  state_r;
  kbd_state_t  state_nxt;
  key_result_t result;
  key_result_t res_r;
  kbd_state_t  out_state_r;
  logic        out_valid_r;
  logic        out_free;
  logic        s1_adv;

  // Result register frees up when empty or being taken this cycle.
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  scs1_decode u_decode (
    .scan_byte (s1_byte_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Input register: load on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_scan_byte;
    end
  end

  // Advance the flags only when the byte moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r       <= result;
      out_state_r <= state_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_valid  = res_r.char_valid;
  assign out_ascii_char  = res_r.ascii_char;
  assign out_unknown_key = res_r.unknown_key;
  assign out_ctrl_down   = out_state_r.ctrl;
  assign out_shift_down  = out_state_r.shift;
  assign out_alt_down    = out_state_r.alt;
  assign out_caps_on     = out_state_r.caps;

endmodule
